### rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define AFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/afc_pkg.sv
// types and constants for the box against frustum cull block
package afc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int PLANE_REGS  = 6;
  localparam int PLANE_W     = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int COORD_W     = 16;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int OFFSET_SHIFT = 14;

  typedef struct packed {
    logic        [15:0] box_tag;
    logic signed [15:0] min_x;
    logic signed [15:0] min_y;
    logic signed [15:0] min_z;
    logic signed [15:0] max_x;
    logic signed [15:0] max_y;
    logic signed [15:0] max_z;
  } box_t;

  typedef struct packed {
    logic [15:0] result_tag;
    logic        culled;
  } res_t;

  // word handed from cell to cell
  typedef struct packed {
    logic valid;
    box_t box;
    logic culled;
  } chain_word_t;

  // positive vertex coordinate for one axis
  function automatic logic signed [COORD_W-1:0] pick_vertex(
    input logic signed [COORD_W-1:0] n,
    input logic signed [COORD_W-1:0] lo,
    input logic signed [COORD_W-1:0] hi
  );
    logic positive;
    positive = !n[COORD_W-1] && (n != '0);
    return positive ? hi : lo;
  endfunction

endpackage

### rtl/afc_cell.sv
// one plane test cell: holds one plane, multiplies then compares
module afc_cell import afc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               plane_we_i,
  input  logic [PLANE_W-1:0] plane_i,
  input  chain_word_t        word_i,
  output chain_word_t        word_o
);

  logic [PLANE_W-1:0] plane_q;

  logic signed [COORD_W-1:0] n_x, n_y, n_z, d_val;
  logic signed [COORD_W-1:0] v_x, v_y, v_z;
  logic signed [PROD_W-1:0]  prod_x_d, prod_y_d, prod_z_d;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic                      valid_a_q;
  box_t                      box_a_q;
  logic                      culled_a_q;

  logic signed [SUM_W-1:0]   dot_sum;
  logic signed [SUM_W-1:0]   limit;
  chain_word_t               word_d;
  logic                      valid_q;
  box_t                      box_q;
  logic                      culled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_i;
    end
  end

  assign n_x   = plane_q[63:48];
  assign n_y   = plane_q[47:32];
  assign n_z   = plane_q[31:16];
  assign d_val = plane_q[15:0];

  // stage a: vertex pick and products
  assign v_x = pick_vertex(n_x, word_i.box.min_x, word_i.box.max_x);
  assign v_y = pick_vertex(n_y, word_i.box.min_y, word_i.box.max_y);
  assign v_z = pick_vertex(n_z, word_i.box.min_z, word_i.box.max_z);

  assign prod_x_d = PROD_W'(n_x) * PROD_W'(v_x);
  assign prod_y_d = PROD_W'(n_y) * PROD_W'(v_y);
  assign prod_z_d = PROD_W'(n_z) * PROD_W'(v_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q   <= prod_x_d;
      prod_y_q   <= prod_y_d;
      prod_z_q   <= prod_z_d;
      box_a_q    <= word_i.box;
      culled_a_q <= word_i.culled;
    end
  end

  // stage b: exact sum against minus offset at 14 fraction bits
  assign dot_sum = SUM_W'(prod_x_q) + SUM_W'(prod_y_q) + SUM_W'(prod_z_q);
  assign limit   = (-SUM_W'(d_val)) <<< OFFSET_SHIFT;

  always_comb begin
    word_d        = '0;
    word_d.valid  = valid_a_q;
    word_d.box    = box_a_q;
    word_d.culled = culled_a_q | (dot_sum < limit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= word_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      box_q    <= word_d.box;
      culled_q <= word_d.culled;
    end
  end

  always_comb begin
    word_o        = '0;
    word_o.valid  = valid_q;
    word_o.box    = box_q;
    word_o.culled = culled_q;
  end

endmodule

### rtl/aabb_frustum_cull_core.sv
// box against frustum cull: one plane cell per plane
// throughput one box per cycle unless stalled; each cell has a product and a compare stage
// the whole chain advances together and freezes only while a result waits stalled
// reset clears the plane registers to zero (no plane culls) and all valid flags
// payload registers are not reset
module aabb_frustum_cull_core import afc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  box_t                 in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output res_t                 out_word_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [PLANE_W-1:0]   cfg_data_i
);

`include "assert_macros.svh"

  // chain words: entry k feeds cell k, last entry is the output register
  chain_word_t chain [PLANE_COUNT+1];
  logic        advance;

  // the chain moves unless the output word is held back
  assign advance    = !chain[PLANE_COUNT].valid || !out_stall_i;
  assign in_stall_o = !advance;

  always_comb begin
    chain[0]        = '0;
    chain[0].valid  = in_valid_i;
    chain[0].box    = in_word_i;
    chain[0].culled = 1'b0;
  end

  for (genvar k = 0; k < PLANE_COUNT; k++) begin : g_cell
    logic plane_we;
    // planes beyond the register list have none and stay zero
    if (k < PLANE_REGS) begin : g_wr
      assign plane_we = cfg_we_i && (cfg_idx_i == CFG_IDX_W'(k));
    end else begin : g_nowr
      assign plane_we = 1'b0;
    end

    afc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (advance),
      .plane_we_i (plane_we),
      .plane_i    (cfg_data_i),
      .word_i     (chain[k]),
      .word_o     (chain[k+1])
    );
  end

  assign out_valid_o           = chain[PLANE_COUNT].valid;
  assign out_word_o.result_tag = chain[PLANE_COUNT].box.box_tag;
  assign out_word_o.culled     = chain[PLANE_COUNT].culled;

  // back pressure only while a finished word waits
  `AFC_ASSERT_IMP(a_stall_only_when_held, clk_i, rst_ni, in_stall_o, out_valid_o)

  // a held output freezes the first cell's word
  `AFC_ASSERT_NXT(a_chain_frozen, clk_i, rst_ni, out_valid_o && out_stall_i,
                  $stable(chain[1]))

  // a held output keeps its tag and culled flag
  `AFC_ASSERT_NXT(a_result_kept, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(out_word_o))

endmodule

### tb/sv/aabb_frustum_cull_core_tb.sv
// self-checking testbench for the box against frustum cull core
import afc_pkg::*;

class cull_checker;
  logic [PLANE_W-1:0] planes[PLANE_REGS];
  res_t               verdict_q[$];
  int                 errors;
  int                 results_seen;

  function new();
    foreach (planes[i]) planes[i] = '0;
    errors       = 0;
    results_seen = 0;
  endfunction

  function void set_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] value);
    if (idx < PLANE_REGS) planes[idx] = value;
  endfunction

  // p-vertex test against every plane, exact in 64 bits
  function bit box_is_culled(box_t b);
    longint             lo[3], hi[3], n[3];
    longint             dot, limit, offs;
    logic signed [15:0] f;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    for (int p = 0; p < PLANE_COUNT && p < PLANE_REGS; p++) begin
      f = planes[p][63:48]; n[0] = f;
      f = planes[p][47:32]; n[1] = f;
      f = planes[p][31:16]; n[2] = f;
      f = planes[p][15:0];  offs = f;
      limit = -offs * (longint'(1) << OFFSET_SHIFT);
      dot = 0;
      for (int a = 0; a < 3; a++) dot += n[a] * ((n[a] > 0) ? hi[a] : lo[a]);
      if (dot < limit) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void note_box(box_t b);
    res_t r;
    r.result_tag = b.box_tag;
    r.culled     = box_is_culled(b);
    verdict_q.insert(verdict_q.size(), r);
  endfunction

  function void check_result(res_t got);
    res_t want;
    results_seen++;
    if (verdict_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: tag %h culled %b", got.result_tag, got.culled);
      return;
    end
    want = verdict_q.pop_front();
    if (got.result_tag !== want.result_tag || got.culled !== want.culled) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: tag exp %h got %h, culled exp %b got %b",
                 want.result_tag, got.result_tag, want.culled, got.culled);
    end
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction
endclass

module aabb_frustum_cull_core_tb;

  localparam int IDLE_PCT       = 12;
  localparam int HOLD_CYCLES    = 64;
  localparam int HOLD_AT_FIRST  = 200;
  localparam int HOLD_AT_SECOND = 900;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * PLANE_COUNT + 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  box_t                 in_word;
  logic                 out_valid;
  logic                 out_stall;
  res_t                 out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [PLANE_W-1:0]   cfg_data;

  cull_checker        sb;
  logic [PLANE_W-1:0] plane_set[PLANE_REGS];
  bit                 steady;       // no random gaps on either side while set
  int                 hold_left;
  int                 holds_done;
  int                 quiet_cycles;

  aabb_frustum_cull_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // clock: period 8, rising edge at the start
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // monitor: every handshake is seen at the rising edge, before the flops move
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) sb.set_plane(cfg_idx, cfg_data);
      if (in_valid && !in_stall) sb.note_box(in_word);
      if (out_valid && !out_stall) sb.check_result(out_word);
      // watchdog on cycles with no word moving either way
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver: random stalls, plus two long hold-offs so the chain backs up
  always @(negedge clk_i) begin
    if (hold_left == 0 && holds_done < 2 && in_valid &&
        sb.results_seen >= ((holds_done == 0) ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
      hold_left  = HOLD_CYCLES;
      holds_done = holds_done + 1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // one of the values that sit on a boundary of a 16 bit signed field, or a random value
  function automatic logic [15:0] edge16();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
    return {16'(nx), 16'(ny), 16'(nz), 16'(d)};
  endfunction

  // normal components within plus or minus 1.0, offset anywhere
  function automatic logic [PLANE_W-1:0] unit_plane();
    int c[3];
    foreach (c[a]) c[a] = int'($urandom_range(32768)) - 16384;
    return pack_plane(c[0], c[1], c[2], int'($urandom_range(65535)));
  endfunction

  function automatic box_t mk_box(int tag, int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.box_tag = 16'(tag);
    b.min_x = 16'(lx); b.min_y = 16'(ly); b.min_z = 16'(lz);
    b.max_x = 16'(hx); b.max_y = 16'(hy); b.max_z = 16'(hz);
    return b;
  endfunction

  // mostly proper boxes of modest size, some inverted, some wild
  function automatic box_t make_box();
    box_t        b;
    logic [15:0] lo[3], hi[3];
    logic [15:0] c, e;
    int          pick;
    pick = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      c = 16'($urandom);
      e = 16'($urandom_range(2047));
      if (pick < 70) begin
        lo[a] = c - e; hi[a] = c + e;
      end else if (pick < 80) begin
        lo[a] = c + e; hi[a] = c - e;
      end else if (pick < 90) begin
        lo[a] = 16'($urandom); hi[a] = 16'($urandom);
      end else begin
        lo[a] = edge16(); hi[a] = edge16();
      end
    end
    b.box_tag = 16'($urandom);
    b.min_x = lo[0]; b.min_y = lo[1]; b.min_z = lo[2];
    b.max_x = hi[0]; b.max_y = hi[1]; b.max_z = hi[2];
    return b;
  endfunction

  // offer one word from a falling edge until it is taken, with random gaps first
  task automatic send_box(box_t b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      in_word  <= box_t'($bits(box_t)'({$urandom, $urandom, $urandom, $urandom}));
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= b;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every verdict is back, block then idle
  task automatic end_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // write all plane registers from plane_set, optionally poke the spare indexes
  task automatic load_planes(bit poke_spare);
    for (int i = 0; i < PLANE_REGS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= plane_set[i];
      @(negedge clk_i);
    end
    if (poke_spare) begin
      // indexes past the last plane must be ignored
      for (int k = PLANE_REGS; k < (1 << CFG_IDX_W); k++) begin
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_IDX_W'(k);
        cfg_data <= {$urandom, $urandom};
        @(negedge clk_i);
      end
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase;
    int n;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    out_stall    = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    steady       = 1'b0;
    hold_left    = 0;
    holds_done   = 0;
    quiet_cycles = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // planes still at reset: all zero, nothing may be culled
    send_box(mk_box(16'hffff, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(0, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(16'h5a5a, 500, 500, 500, -500, -500, -500));
    send_box(mk_box(16'ha5a5, -32768, -32768, -32768, 32767, 32767, 32767));
    end_phase();

    // x >= -16 and y <= 0 half spaces, spare indexes poked with junk
    foreach (plane_set[i]) plane_set[i] = '0;
    plane_set[0] = pack_plane(16'h4000, 0, 0, 16);
    plane_set[1] = pack_plane(0, 16'hc000, 0, 0);
    load_planes(1'b1);
    send_box(mk_box(1, -100, 0, 0, -16, 0, 0));          // dot equals -d: kept
    send_box(mk_box(2, -100, 0, 0, -17, 0, 0));          // one lsb past: culled
    send_box(mk_box(3, -100, 1, 0, 100, 5, 0));          // outside the y plane
    send_box(mk_box(4, 200, -5, 0, -100, -5, 0));        // inverted x, corners not swapped
    send_box(mk_box(5, -100, -5, 0, 200, -5, 0));
    send_box(mk_box(6, 0, -32768, 0, 32767, 32767, 0));
    end_phase();

    // extreme normals and offsets; zero normals with positive offset never cull
    foreach (plane_set[i]) plane_set[i] = pack_plane(0, 0, 0, 16'h7fff);
    plane_set[0] = pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    plane_set[5] = pack_plane(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    load_planes(1'b1);
    send_box(mk_box(7, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(mk_box(8, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(mk_box(9, 0, 0, 0, 0, 0, 0));
    send_box(mk_box(10, -32768, 32767, -32768, 32767, -32768, 32767));
    end_phase();

    // zero normal with negative offset culls all; zero x component takes min
    foreach (plane_set[i]) plane_set[i] = '0;
    plane_set[3] = pack_plane(0, 0, 0, 16'hffff);
    load_planes(1'b0);
    send_box(mk_box(11, 0, 0, 0, 10, 10, 10));
    end_phase();
    foreach (plane_set[i]) plane_set[i] = '0;
    plane_set[2] = pack_plane(0, 16'h4000, 0, 0);
    load_planes(1'b0);
    send_box(mk_box(12, 32767, -10, 0, -32768, -1, 0));
    send_box(mk_box(13, -32768, -10, 0, 32767, 0, 0));
    end_phase();

    // random phases, each with its own plane setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        case (phase % 4)
          0, 1:    plane_set[i] = ($urandom_range(99) < 35) ? unit_plane() : '0;
          2:       plane_set[i] = {edge16(), edge16(), edge16(), edge16()};
          default: plane_set[i] = {$urandom, $urandom};
        endcase
      end
      steady = (phase == 3);
      load_planes(phase[0]);
      n = $urandom_range(60, 140);
      repeat (n) send_box(make_box());
      sent += n;
      end_phase();
      phase++;
    end
    steady = 1'b0;

    // let any stray result show up before judging
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0d results never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
